// ===== hdl/mkslpd_pkg.sv =====
// Shared types and constants for the multi-key short/long press detector.
// No dependencies; every other file in hdl/ refers to this package by scope.
package mkslpd_pkg;

  // Widths of the request and response payload fields.
  localparam int unsigned OpW        = 1;
  localparam int unsigned KeyLevelsW = 4;
  localparam int unsigned KeyStatesW = 8;
  localparam int unsigned ShownKeys  = 4;

  // Configuration port.
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned ThreshW   = 16;

  localparam logic [CfgIdxW-1:0] CfgLongIdx    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMinIdx     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgReleaseIdx = 2'd2;

  localparam logic [ThreshW-1:0] LongResetVal = 16'd100;
  localparam logic [ThreshW-1:0] MinResetVal  = 16'd2;
  localparam logic               RelResetVal  = 1'b1;

  typedef enum logic [OpW-1:0] {
    OpScan  = 1'b0,
    OpClear = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KeyReleased = 2'd0,
    KeyShort    = 2'd1,
    KeyLong     = 2'd2
  } key_state_e;

  // Thresholds and polarity seen by every lane.
  typedef struct packed {
    logic [ThreshW-1:0] long_ticks;
    logic [ThreshW-1:0] min_ticks;
    logic               release_level;
  } cfg_t;

  // Per-lane update strobes for one accepted request.
  typedef struct packed {
    logic scan;
    logic clear;
  } lane_ctrl_t;

endpackage

// ===== hdl/mkslpd_if.sv =====
// Valid/ready channel interfaces for the press detector request and response.
// Depends on mkslpd_pkg for the field widths.
interface mkslpd_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [mkslpd_pkg::OpW-1:0]           operation;
  logic [mkslpd_pkg::KeyLevelsW-1:0]    key_levels;
  logic [mkslpd_pkg::KeyLevelsW-1:0]    clear_mask;

  modport source (output valid, output operation, output key_levels, output clear_mask,
                  input ready);
  modport sink   (input valid, input operation, input key_levels, input clear_mask,
                  output ready);
endinterface

interface mkslpd_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [mkslpd_pkg::KeyStatesW-1:0]    key_states;
  logic                                 any_event;

  modport source (output valid, output key_states, output any_event, input ready);
  modport sink   (input valid, input key_states, input any_event, output ready);
endinterface

// ===== hdl/multi_key_short_long_press_detector_core.sv =====
// Multi-key short/long press detector: one lane per key plus a merging output stage.
// Latency: a request's response is valid in the cycle after it is accepted.
// Throughput: one request per cycle unless rsp_o stalls; one output reg, refilled on drain.
// Reset: counters zero, all keys armed and released, thresholds 100 and 2, release level 1.
// Depends on mkslpd_pkg, mkslpd_if, mkslpd_lane and mkslpd_merge.
module multi_key_short_long_press_detector_core #(
  parameter int unsigned NUM_KEYS    = 4,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mkslpd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [mkslpd_pkg::CfgDataW-1:0]     cfg_wdata_i,
  mkslpd_req_if.sink                          req_i,
  mkslpd_rsp_if.source                        rsp_o
);

  mkslpd_pkg::cfg_t       cfg_q, cfg_d;
  mkslpd_pkg::lane_ctrl_t ctrl;
  mkslpd_pkg::key_state_e lane_state [NUM_KEYS];
  logic                   req_fire;
  logic                   can_load;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mkslpd_pkg::CfgLongIdx:    cfg_d.long_ticks    = cfg_wdata_i;
        mkslpd_pkg::CfgMinIdx:     cfg_d.min_ticks     = cfg_wdata_i;
        mkslpd_pkg::CfgReleaseIdx: cfg_d.release_level = cfg_wdata_i[0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_ticks    <= mkslpd_pkg::LongResetVal;
      cfg_q.min_ticks     <= mkslpd_pkg::MinResetVal;
      cfg_q.release_level <= mkslpd_pkg::RelResetVal;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign req_i.ready = can_load;
  assign req_fire    = req_i.valid && can_load;
  assign ctrl.scan   = req_fire && (req_i.operation == mkslpd_pkg::OpScan);
  assign ctrl.clear  = req_fire && (req_i.operation == mkslpd_pkg::OpClear);

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic                   level;
    mkslpd_pkg::lane_ctrl_t lane_ctrl;

    // Keys beyond the request's fields read as level low and are never cleared.
    if (k < mkslpd_pkg::KeyLevelsW) begin : g_wired
      assign level           = req_i.key_levels[k];
      assign lane_ctrl.scan  = ctrl.scan;
      assign lane_ctrl.clear = ctrl.clear && req_i.clear_mask[k];
    end else begin : g_extra
      assign level           = 1'b0;
      assign lane_ctrl.scan  = ctrl.scan;
      assign lane_ctrl.clear = 1'b0;
    end

    mkslpd_lane #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cfg_i     (cfg_q),
      .ctrl_i    (lane_ctrl),
      .pressed_i (level != cfg_q.release_level),
      .state_d_o (lane_state[k])
    );
  end

  mkslpd_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (req_fire),
    .lane_state_i (lane_state),
    .out_ready_i  (rsp_o.ready),
    .out_valid_o  (rsp_o.valid),
    .can_load_o   (can_load),
    .key_states_o (rsp_o.key_states),
    .any_event_o  (rsp_o.any_event)
  );

endmodule

// ===== hdl/mkslpd_lane.sv =====
// One key lane: saturating hold counter, long-press arm flag and event state.
// Depends on mkslpd_pkg for the configuration and control structs.
module mkslpd_lane #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mkslpd_pkg::cfg_t        cfg_i,
  input  mkslpd_pkg::lane_ctrl_t  ctrl_i,
  input  logic                    pressed_i,
  output mkslpd_pkg::key_state_e  state_d_o
);

  localparam int unsigned CmpW = (COUNT_WIDTH > mkslpd_pkg::ThreshW) ?
                                 COUNT_WIDTH : mkslpd_pkg::ThreshW;

  logic [COUNT_WIDTH-1:0] held_q, held_d, held_inc;
  logic                   armed_q, armed_d;
  mkslpd_pkg::key_state_e state_q, state_d;

  assign held_inc = (&held_q) ? held_q : held_q + 1'b1;

  always_comb begin
    held_d  = held_q;
    armed_d = armed_q;
    state_d = state_q;
    if (ctrl_i.scan) begin
      if (pressed_i) begin
        held_d = held_inc;
        // Once the long event has fired, the state drops back while the key stays down.
        if (!armed_q) begin
          state_d = mkslpd_pkg::KeyReleased;
        end else if (CmpW'(held_inc) >= CmpW'(cfg_i.long_ticks)) begin
          state_d = mkslpd_pkg::KeyLong;
          armed_d = 1'b0;
        end
      end else begin
        if (armed_q) begin
          if (state_q != mkslpd_pkg::KeyLong &&
              CmpW'(held_q) >= CmpW'(cfg_i.min_ticks)) begin
            state_d = mkslpd_pkg::KeyShort;
          end else begin
            state_d = mkslpd_pkg::KeyReleased;
          end
        end
        held_d  = '0;
        armed_d = 1'b1;
      end
    end else if (ctrl_i.clear) begin
      state_d = mkslpd_pkg::KeyReleased;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      armed_q <= 1'b1;
      state_q <= mkslpd_pkg::KeyReleased;
    end else begin
      held_q  <= held_d;
      armed_q <= armed_d;
      state_q <= state_d;
    end
  end

  assign state_d_o = state_d;

endmodule

// ===== hdl/mkslpd_merge.sv =====
// Merges the lane states into the response and holds it in the output register.
// Depends on mkslpd_pkg for the key state codes and payload widths.
module mkslpd_merge #(
  parameter int unsigned NUM_KEYS = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 load_i,
  input  mkslpd_pkg::key_state_e               lane_state_i [NUM_KEYS],
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic                                 can_load_o,
  output logic [mkslpd_pkg::KeyStatesW-1:0]    key_states_o,
  output logic                                 any_event_o
);

  logic                                 valid_q, valid_d;
  logic [mkslpd_pkg::KeyStatesW-1:0]    states_q, states_d;
  logic                                 any_q, any_d;

  // Only the first four keys are visible in the packed field; all keys feed the flag.
  always_comb begin
    states_d = '0;
    any_d    = 1'b0;
    for (int unsigned k = 0; k < NUM_KEYS; k++) begin
      if (k < mkslpd_pkg::ShownKeys) begin
        states_d[2*k +: 2] = lane_state_i[k];
      end
      if (lane_state_i[k] != mkslpd_pkg::KeyReleased) begin
        any_d = 1'b1;
      end
    end
  end

  assign can_load_o = !valid_q || out_ready_i;
  assign valid_d    = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      states_q <= states_d;
      any_q    <= any_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign key_states_o = states_q;
  assign any_event_o  = any_q;

endmodule
